### design/sasu_pkg.sv
// Shared constants, codes, types and band tables for the single-axis attitude step unit.
package sasu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ErrW  = 33;
  localparam int unsigned XW    = 34;
  localparam int unsigned ProdW = 64;
  localparam int unsigned NumW  = 96;
  localparam int unsigned DenW  = 69;
  localparam int unsigned QuoW  = 15;
  localparam int unsigned RateW = 24;
  localparam int unsigned RdbW  = 16;

  localparam logic [ErrW-1:0] BandLow  = 33'd702762;
  localparam logic [ErrW-1:0] BandMid  = 33'd4685083;
  localparam logic [ErrW-1:0] BandHigh = 33'd14055248;
  localparam logic [ErrW-1:0] BandMax  = 33'd46850825;

  localparam logic [RateW-1:0] RateFine = 24'd46851;
  localparam logic [RateW-1:0] RateLow  = 24'd1171271;
  localparam logic [RateW-1:0] RateMid  = 24'd2342541;
  localparam logic [RateW-1:0] RateHigh = 24'd4685083;
  localparam logic [RateW-1:0] RateMax  = 24'd9370165;

  localparam logic [RdbW-1:0] RateDbCap  = 16'd46851;
  localparam logic [RdbW-1:0] RateDbFine = 16'd23425;

  localparam logic signed [DataW-1:0] RateNull = 32'sd469;

  localparam logic [DataW-1:0] InertiaReset = 32'd65536;
  localparam logic [DataW-1:0] TorqueReset  = 32'd256;
  localparam logic [DataW-1:0] StepReset    = 32'd65536;

  typedef enum logic [2:0] {
    CFG_INERTIA_PITCH,
    CFG_INERTIA_YAW,
    CFG_INERTIA_ROLL,
    CFG_TORQUE_PITCH,
    CFG_TORQUE_YAW,
    CFG_TORQUE_ROLL,
    CFG_STEP_TIME
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_PITCH,
    AXIS_YAW,
    AXIS_ROLL
  } axis_e;

  typedef enum logic [2:0] {
    BAND_FINE,
    BAND_LOW,
    BAND_MID,
    BAND_HIGH,
    BAND_MAX
  } band_e;

  typedef struct packed {
    logic neg;
    logic drive;
    logic reached;
    logic sat;
    logic nz;
  } sasu_side_t;

  function automatic logic [RateW-1:0] band_rate(input band_e band);
    logic [RateW-1:0] r;
    case (band)
      BAND_FINE: r = RateFine;
      BAND_LOW:  r = RateLow;
      BAND_MID:  r = RateMid;
      BAND_HIGH: r = RateHigh;
      BAND_MAX:  r = RateMax;
      default:   r = RateMax;
    endcase
    return r;
  endfunction

  function automatic logic [RdbW-1:0] band_rate_db(input band_e band);
    logic [RdbW-1:0] d;
    case (band)
      BAND_FINE: d = RateDbFine;
      default:   d = RateDbCap;
    endcase
    return d;
  endfunction

endpackage

### design/sasu_div_pipe.sv
// Pipelined restoring divider: one quotient bit per register stage.
module sasu_div_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  sasu_pkg::sasu_side_t          side_i,
  input  logic [sasu_pkg::NumW-1:0]     num_i,
  input  logic [sasu_pkg::DenW-1:0]     den_i,
  output logic                          vld_o,
  output sasu_pkg::sasu_side_t          side_o,
  output logic [sasu_pkg::QuoW-1:0]     quo_o
);
  import sasu_pkg::*;

  logic       [QuoW:0]    vld_in;
  sasu_side_t             side_in [QuoW+1];
  logic [NumW-1:0]        rem_in  [QuoW+1];
  logic [DenW-1:0]        den_in  [QuoW+1];
  logic [QuoW-1:0]        quo_in  [QuoW+1];

  assign vld_in[0]  = vld_i;
  assign side_in[0] = side_i;
  assign rem_in[0]  = num_i;
  assign den_in[0]  = den_i;
  assign quo_in[0]  = '0;

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    localparam int unsigned Sh = QuoW - 1 - k;

    logic [NumW-1:0] sub_d;
    logic            ge_d;
    logic [NumW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;
    logic            vld_q;
    sasu_side_t      side_q;
    logic [NumW-1:0] rem_q;
    logic [DenW-1:0] den_q;
    logic [QuoW-1:0] quo_q;

    always_comb begin
      sub_d = NumW'(den_in[k]) << Sh;
      ge_d  = rem_in[k] >= sub_d;
      rem_d = ge_d ? (rem_in[k] - sub_d) : rem_in[k];
      quo_d = quo_in[k];
      quo_d[Sh] = ge_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (adv_i) begin
        vld_q <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q <= side_in[k];
        rem_q  <= rem_d;
        den_q  <= den_in[k];
        quo_q  <= quo_d;
      end
    end

    assign vld_in[k+1]  = vld_q;
    assign side_in[k+1] = side_q;
    assign rem_in[k+1]  = rem_q;
    assign den_in[k+1]  = den_q;
    assign quo_in[k+1]  = quo_q;
  end

  assign vld_o  = vld_in[QuoW];
  assign side_o = side_in[QuoW];
  assign quo_o  = quo_in[QuoW];

endmodule

### design/single_axis_attitude_step_unit.sv
// Top level: single-axis attitude step, pipelined thruster level and reached flag.
//
//   channel  direction  transfer content
//   s_axis   in         tdata: target, current, rate, deadband, mass; tuser: axis
//   m_axis   out        tdata: thrust level, reached
//   cfg      in         write enable, register index, 32-bit data
//
// One item enters per cycle unless a result waits at the output.
// An item passes eight datapath stages, fifteen divider stages and the output register.
// The whole pipe holds while a result waits at the output; no item is lost or repeated.
// Reset clears valid bits and loads register defaults; no clearing pass.
module single_axis_attitude_step_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] target_angle, [63:32] current_angle, [95:64] rotation_rate,
  // [126:96] angle_deadband, [158:127] craft_mass, [159] zero
  input  logic [159:0]                s_axis_tdata,
  // [1:0] axis_select
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] thrust_level, [16] reached, [23:17] zero
  output logic [23:0]                 m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [sasu_pkg::DataW-1:0]  cfg_wdata_i
);
  import sasu_pkg::*;

  logic [DataW-1:0] inertia_q [3];
  logic [DataW-1:0] torque_q  [3];
  logic [DataW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        inertia_q[i] <= InertiaReset;
        torque_q[i]  <= TorqueReset;
      end
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INERTIA_PITCH: inertia_q[AXIS_PITCH] <= cfg_wdata_i;
        CFG_INERTIA_YAW:   inertia_q[AXIS_YAW]   <= cfg_wdata_i;
        CFG_INERTIA_ROLL:  inertia_q[AXIS_ROLL]  <= cfg_wdata_i;
        CFG_TORQUE_PITCH:  torque_q[AXIS_PITCH]  <= cfg_wdata_i;
        CFG_TORQUE_YAW:    torque_q[AXIS_YAW]    <= cfg_wdata_i;
        CFG_TORQUE_ROLL:   torque_q[AXIS_ROLL]   <= cfg_wdata_i;
        CFG_STEP_TIME:     step_q                <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic in_xfer;
  logic out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  logic signed [DataW-1:0] in_target;
  logic signed [DataW-1:0] in_current;
  logic signed [DataW-1:0] in_rate;
  logic        [30:0]      in_db;
  logic        [DataW-1:0] in_mass;
  logic        [1:0]       in_axis;

  assign in_target  = s_axis_tdata[31:0];
  assign in_current = s_axis_tdata[63:32];
  assign in_rate    = s_axis_tdata[95:64];
  assign in_db      = s_axis_tdata[126:96];
  assign in_mass    = s_axis_tdata[158:127];
  assign in_axis    = s_axis_tuser;

  logic [7:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[6:0], in_xfer};
    end
  end

  // stage 1: angle error, axis select, products
  logic                    axis_ok_d;
  logic [DataW-1:0]        inert_d;
  logic [DataW-1:0]        torq_d;
  logic signed [ErrW-1:0]  err1_q;
  logic signed [DataW-1:0] rate1_q;
  logic [30:0]             db1_q;
  logic                    axis_ok1_q;
  logic [ProdW-1:0]        m1_q;
  logic [ProdW-1:0]        den1_q;

  always_comb begin
    axis_ok_d = 1'b1;
    inert_d   = inertia_q[AXIS_PITCH];
    torq_d    = torque_q[AXIS_PITCH];
    case (in_axis)
      AXIS_PITCH: begin
        inert_d = inertia_q[AXIS_PITCH];
        torq_d  = torque_q[AXIS_PITCH];
      end
      AXIS_YAW: begin
        inert_d = inertia_q[AXIS_YAW];
        torq_d  = torque_q[AXIS_YAW];
      end
      AXIS_ROLL: begin
        inert_d = inertia_q[AXIS_ROLL];
        torq_d  = torque_q[AXIS_ROLL];
      end
      default: axis_ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err1_q     <= ErrW'(in_target) - ErrW'(in_current);
      rate1_q    <= in_rate;
      db1_q      <= in_db;
      axis_ok1_q <= axis_ok_d;
      m1_q       <= ProdW'(in_mass) * ProdW'(inert_d);
      den1_q     <= ProdW'(step_q) * ProdW'(torq_d);
    end
  end

  // stage 2: error magnitude, rate null test
  logic [ErrW-1:0]         aerr2_q;
  logic                    neg2_q;
  logic                    zero2_q;
  logic                    rsmall2_q;
  logic signed [DataW-1:0] rate2_q;
  logic [30:0]             db2_q;
  logic                    axis_ok2_q;
  logic [ProdW-1:0]        m2_q;
  logic [ProdW-1:0]        den2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      aerr2_q    <= err1_q[ErrW-1] ? ErrW'(-err1_q) : ErrW'(err1_q);
      neg2_q     <= err1_q[ErrW-1];
      zero2_q    <= err1_q == '0;
      rsmall2_q  <= (rate1_q < RateNull) && (rate1_q > -RateNull);
      rate2_q    <= rate1_q;
      db2_q      <= db1_q;
      axis_ok2_q <= axis_ok1_q;
      m2_q       <= m1_q;
      den2_q     <= den1_q;
    end
  end

  // stage 3: deadband and band compares
  band_e                   band_d;
  logic                    indb3_q;
  band_e                   band3_q;
  logic                    neg3_q;
  logic                    zero3_q;
  logic                    rsmall3_q;
  logic signed [DataW-1:0] rate3_q;
  logic                    axis_ok3_q;
  logic [ProdW-1:0]        m3_q;
  logic [ProdW-1:0]        den3_q;

  always_comb begin
    if (aerr2_q < BandLow) begin
      band_d = BAND_FINE;
    end else if (aerr2_q < BandMid) begin
      band_d = BAND_LOW;
    end else if (aerr2_q < BandHigh) begin
      band_d = BAND_MID;
    end else if (aerr2_q < BandMax) begin
      band_d = BAND_HIGH;
    end else begin
      band_d = BAND_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      indb3_q    <= aerr2_q < ErrW'(db2_q);
      band3_q    <= band_d;
      neg3_q     <= neg2_q;
      zero3_q    <= zero2_q;
      rsmall3_q  <= rsmall2_q;
      rate3_q    <= rate2_q;
      axis_ok3_q <= axis_ok2_q;
      m3_q       <= m2_q;
      den3_q     <= den2_q;
    end
  end

  // stage 4: rate error
  logic signed [XW-1:0] rtgt_d;
  logic signed [XW-1:0] x4_q;
  logic [RdbW-1:0]      rdb4_q;
  logic                 indb4_q;
  logic                 zero4_q;
  logic                 rsmall4_q;
  logic                 axis_ok4_q;
  logic [ProdW-1:0]     m4_q;
  logic [ProdW-1:0]     den4_q;

  assign rtgt_d = neg3_q ? -XW'(band_rate(band3_q)) : XW'(band_rate(band3_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x4_q       <= indb3_q ? -XW'(rate3_q) : (rtgt_d - XW'(rate3_q));
      rdb4_q     <= band_rate_db(band3_q);
      indb4_q    <= indb3_q;
      zero4_q    <= zero3_q;
      rsmall4_q  <= rsmall3_q;
      axis_ok4_q <= axis_ok3_q;
      m4_q       <= m3_q;
      den4_q     <= den3_q;
    end
  end

  // stage 5: magnitude and drive decision
  logic [XW-1:0]    ax_d;
  logic [DataW-1:0] mag5_q;
  sasu_side_t       side5_q;
  logic [ProdW-1:0] m5_q;
  logic [ProdW-1:0] den5_q;

  assign ax_d = x4_q[XW-1] ? XW'(-x4_q) : XW'(x4_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag5_q          <= ax_d[DataW-1:0];
      side5_q.neg     <= x4_q[XW-1];
      side5_q.drive   <= axis_ok4_q &&
                         (indb4_q ? !rsmall4_q : (zero4_q || (ax_d > XW'(rdb4_q))));
      side5_q.reached <= axis_ok4_q && indb4_q && rsmall4_q;
      side5_q.sat     <= 1'b0;
      side5_q.nz      <= 1'b0;
      m5_q            <= m4_q;
      den5_q          <= den4_q;
    end
  end

  // stage 6: partial products
  logic [ProdW-1:0] plo6_q;
  logic [ProdW-1:0] phi6_q;
  sasu_side_t       side6_q;
  logic [ProdW-1:0] den6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo6_q  <= ProdW'(m5_q[31:0]) * ProdW'(mag5_q);
      phi6_q  <= ProdW'(m5_q[63:32]) * ProdW'(mag5_q);
      side6_q <= side5_q;
      den6_q  <= den5_q;
    end
  end

  // stage 7: numerator sum
  logic [NumW-1:0] num7_q;
  logic [DenW-1:0] den7_q;
  sasu_side_t      side7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num7_q  <= NumW'(plo6_q) + {phi6_q, 32'd0};
      den7_q  <= {den6_q, 5'd0};
      side7_q <= side6_q;
    end
  end

  // stage 8: saturation test
  logic [NumW-1:0] num8_q;
  logic [DenW-1:0] den8_q;
  sasu_side_t      side8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num8_q          <= num7_q;
      den8_q          <= den7_q;
      side8_q.neg     <= side7_q.neg;
      side8_q.drive   <= side7_q.drive;
      side8_q.reached <= side7_q.reached;
      side8_q.sat     <= num7_q >= NumW'({den7_q, 15'd0});
      side8_q.nz      <= num7_q != '0;
    end
  end

  logic            div_vld;
  sasu_side_t      div_side;
  logic [QuoW-1:0] div_quo;

  sasu_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (vld_q[7]),
    .side_i (side8_q),
    .num_i  (num8_q),
    .den_i  (den8_q),
    .vld_o  (div_vld),
    .side_o (div_side),
    .quo_o  (div_quo)
  );

  // output register
  logic signed [15:0] level_d;
  logic [15:0]        level_q;
  logic               reached_q;

  always_comb begin
    if (!div_side.drive || !div_side.nz) begin
      level_d = '0;
    end else if (div_side.sat) begin
      level_d = div_side.neg ? 16'sh8000 : 16'sh7fff;
    end else begin
      level_d = div_side.neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      level_q   <= level_d;
      reached_q <= div_side.reached;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, reached_q, level_q};

  a_reached_zero_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("reached result carries nonzero thrust level");

  a_reached_no_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld && div_side.reached) |-> !div_side.drive)
    else $error("item both reached and driving");

  a_empty_stays_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q == '0) && !in_xfer) |=> (vld_q == '0))
    else $error("valid appeared in empty front pipe");

endmodule

### sim/single_axis_attitude_step_unit_tb.sv
// Testbench: directed table and random control samples checked against fixed expectations or a bit-exact predictor.
module single_axis_attitude_step_unit_tb;
  import sasu_pkg::*;

  typedef struct packed {
    logic signed [31:0] target_angle;
    logic signed [31:0] current_angle;
    logic signed [31:0] rotation_rate;
    logic [1:0]         axis_select;
    logic [30:0]        angle_deadband;
    logic [31:0]        craft_mass;
  } attitude_sample_t;

  typedef struct packed {
    logic signed [15:0] thrust_level;
    logic               reached;
  } thrust_cmd_t;

  typedef struct {
    attitude_sample_t s;
    logic             typed;
    thrust_cmd_t      res;
  } step_case_t;

  localparam logic [1:0] AxisUnused = 2'd3;

  localparam logic [32:0] BandFineEdge = 33'd702762;
  localparam logic [32:0] BandLowEdge  = 33'd4685083;
  localparam logic [32:0] BandMidEdge  = 33'd14055248;
  localparam logic [32:0] BandHighEdge = 33'd46850825;

  localparam logic [23:0] RateFineQ   = 24'd46851;
  localparam logic [23:0] RateLowQ    = 24'd1171271;
  localparam logic [23:0] RateMidQ    = 24'd2342541;
  localparam logic [23:0] RateHighQ   = 24'd4685083;
  localparam logic [23:0] RateMaxQ    = 24'd9370165;
  localparam logic [23:0] RateDbLimit = 24'd46851;
  localparam logic [32:0] RateNullQ   = 33'd469;

  localparam int NumCases = 25;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;

  logic [31:0] inertia_q [3];
  logic [31:0] torque_q [3];
  logic [31:0] step_q;

  thrust_cmd_t expected_cmds [$];
  thrust_cmd_t staged_cmd = '0;
  int unsigned fault_count = 0;
  int unsigned stall_left = 0;
  logic        sink_fast = 1'b0;
  logic        src_fast;

  step_case_t step_cases [NumCases] = '{
    '{'{32'sd100000000, 32'sd0, 32'sd0, AxisUnused, 31'd0, 32'd1000}, 1'b1, '{16'sd0, 1'b0}},
    '{'{32'sd5, 32'sd5, 32'sd0, AXIS_PITCH, 31'd10, 32'd1000}, 1'b1, '{16'sd0, 1'b1}},
    '{'{-32'sd20, -32'sd25, 32'sd468, AXIS_YAW, 31'd6, 32'd1000}, 1'b1, '{16'sd0, 1'b1}},
    '{'{32'sd0, 32'sd0, -32'sd468, AXIS_ROLL, 31'd1, 32'd1000}, 1'b1, '{16'sd0, 1'b1}},
    '{'{32'sd0, 32'sd0, 32'sd469, AXIS_PITCH, 31'd1, 32'd100}, 1'b0, '0},
    '{'{32'sd0, 32'sd0, 32'sh80000000, AXIS_YAW, 31'd1, 32'd1}, 1'b1, '{16'sh7FFF, 1'b0}},
    '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, AXIS_ROLL, 31'd0, 32'd1}, 1'b0, '0},
    '{'{32'sh80000000, 32'sh7FFFFFFF, 32'sd0, AXIS_PITCH, 31'd0, 32'd1000}, 1'b1,
      '{16'sh8000, 1'b0}},
    '{'{32'sd50000000, 32'sd0, 32'sd0, AXIS_YAW, 31'd0, 32'd0}, 1'b1, '{16'sd0, 1'b0}},
    '{'{32'sd12345, 32'sd12345, 32'sd0, AXIS_ROLL, 31'd0, 32'd1}, 1'b0, '0},
    '{'{-32'sd777, -32'sd777, 32'sd46851, AXIS_PITCH, 31'd0, 32'd1000}, 1'b0, '0},
    '{'{32'sd702761, 32'sd0, 32'sd0, AXIS_PITCH, 31'd0, 32'd100}, 1'b0, '0},
    '{'{32'sd702762, 32'sd0, 32'sd0, AXIS_YAW, 31'd0, 32'd10}, 1'b0, '0},
    '{'{32'sd0, 32'sd4685082, 32'sd0, AXIS_ROLL, 31'd0, 32'd10}, 1'b0, '0},
    '{'{32'sd0, 32'sd4685083, 32'sd0, AXIS_PITCH, 31'd0, 32'd10}, 1'b0, '0},
    '{'{32'sd14055247, 32'sd0, 32'sd1000, AXIS_YAW, 31'd0, 32'd5}, 1'b0, '0},
    '{'{-32'sd14055248, 32'sd0, -32'sd1000, AXIS_ROLL, 31'd0, 32'd5}, 1'b0, '0},
    '{'{32'sd46850824, 32'sd0, 32'sd0, AXIS_PITCH, 31'd0, 32'd2}, 1'b0, '0},
    '{'{32'sd46850825, 32'sd0, 32'sd0, AXIS_YAW, 31'd0, 32'd2}, 1'b0, '0},
    '{'{32'sd1000000, 32'sd0, 32'sd1124420, AXIS_ROLL, 31'd0, 32'd1}, 1'b0, '0},
    '{'{32'sd1000000, 32'sd0, 32'sd1124419, AXIS_PITCH, 31'd0, 32'd1}, 1'b0, '0},
    '{'{32'sd1, 32'sd0, 32'sd23426, AXIS_YAW, 31'd0, 32'd1}, 1'b0, '0},
    '{'{32'sh7FFFFFFF, 32'sd1, 32'sd1000, AXIS_ROLL, 31'h7FFFFFFF, 32'hFFFFFFFF}, 1'b1,
      '{16'sh8000, 1'b0}},
    '{'{32'sd1000, 32'sd0, 32'sh7FFFFFFF, AXIS_PITCH, 31'd0, 32'd1}, 1'b1,
      '{16'sh8000, 1'b0}},
    '{'{32'sd500, 32'sd0, 32'sd0, AXIS_YAW, 31'd500, 32'd1000}, 1'b0, '0}
  };

  single_axis_attitude_step_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic logic [23:0] target_rate_for(input logic [32:0] aerr);
    if (aerr < BandFineEdge) return RateFineQ;
    else if (aerr < BandLowEdge) return RateLowQ;
    else if (aerr < BandMidEdge) return RateMidQ;
    else if (aerr < BandHighEdge) return RateHighQ;
    else return RateMaxQ;
  endfunction

  function automatic logic signed [15:0] thrust_from_rate(input logic [31:0] mass,
                                                          input logic [31:0] inertia,
                                                          input logic [31:0] torque,
                                                          input logic signed [33:0] x);
    logic [33:0]        mag;
    logic [127:0]       num;
    logic [127:0]       den;
    logic [127:0]       quo;
    logic signed [15:0] lvl;
    mag = x[33] ? 34'(-x) : 34'(x);
    num = {96'd0, mass} * {96'd0, inertia} * {94'd0, mag};
    if (num == '0) return '0;
    den = ({96'd0, step_q} * {96'd0, torque}) << 5;
    if (num >= (den << 15)) return x[33] ? 16'sh8000 : 16'sh7FFF;
    quo = num / den;
    lvl = quo[15:0];
    return x[33] ? -lvl : lvl;
  endfunction

  function automatic thrust_cmd_t predict_thrust(input attitude_sample_t s);
    thrust_cmd_t        c;
    logic signed [32:0] err;
    logic [32:0]        aerr;
    logic [32:0]        arate;
    logic signed [33:0] rate_x;
    logic signed [33:0] aim;
    logic signed [33:0] rate_err;
    logic [33:0]        arerr;
    logic [23:0]        aim_mag;
    logic [23:0]        rdb;
    logic [31:0]        inr;
    logic [31:0]        trq;
    c = '0;
    if (s.axis_select > AXIS_ROLL) return c;
    inr = inertia_q[s.axis_select];
    trq = torque_q[s.axis_select];
    err = {s.target_angle[31], s.target_angle} - {s.current_angle[31], s.current_angle};
    aerr = err[32] ? 33'(-err) : 33'(err);
    rate_x = {{2{s.rotation_rate[31]}}, s.rotation_rate};
    if (aerr < {2'b00, s.angle_deadband}) begin
      arate = rate_x[33] ? 33'(-rate_x) : 33'(rate_x);
      if (arate < RateNullQ) c.reached = 1'b1;
      else c.thrust_level = thrust_from_rate(s.craft_mass, inr, trq, -rate_x);
    end else begin
      aim_mag = target_rate_for(aerr);
      rdb = ((aim_mag >> 1) < RateDbLimit) ? (aim_mag >> 1) : RateDbLimit;
      aim = err[32] ? -$signed({10'd0, aim_mag}) : $signed({10'd0, aim_mag});
      rate_err = aim - rate_x;
      arerr = rate_err[33] ? 34'(-rate_err) : 34'(rate_err);
      if (err == 0 || arerr > {10'd0, rdb})
        c.thrust_level = thrust_from_rate(s.craft_mass, inr, trq, rate_err);
    end
    return c;
  endfunction

  function automatic attitude_sample_t random_sample();
    attitude_sample_t s;
    logic [31:0]      mag;
    logic [31:0]      err;
    logic [31:0]      aim;
    s.current_angle = $urandom;
    s.axis_select = ($urandom_range(0, 15) == 0) ? AxisUnused : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: mag = $urandom;
      1: mag = $urandom_range(0, 1) ? '0 : $urandom_range(0, 3000);
      2: mag = 32'(BandFineEdge) + $urandom_range(0, 2000) - 1000;
      3: mag = 32'(BandLowEdge) + $urandom_range(0, 2000) - 1000;
      4: mag = 32'(BandMidEdge) + $urandom_range(0, 2000) - 1000;
      default: mag = 32'(BandHighEdge) + $urandom_range(0, 2000) - 1000;
    endcase
    err = $urandom_range(0, 1) ? -mag : mag;
    s.target_angle = s.current_angle + err;
    case ($urandom_range(0, 3))
      0: s.angle_deadband = '0;
      1: s.angle_deadband = 31'($urandom);
      2: s.angle_deadband = 31'(mag + $urandom_range(0, 2) - 1);
      default: s.angle_deadband = 31'($urandom_range(0, 5000));
    endcase
    aim = 32'(target_rate_for(33'(mag)));
    if (err[31]) aim = -aim;
    case ($urandom_range(0, 3))
      0: s.rotation_rate = $urandom;
      1: s.rotation_rate = $urandom_range(0, 1000) - 500;
      default: s.rotation_rate = aim + $urandom_range(0, 100000) - 50000;
    endcase
    case ($urandom_range(0, 3))
      0: s.craft_mass = $urandom;
      1: s.craft_mass = $urandom_range(0, 3);
      2: s.craft_mass = $urandom_range(0, 2000);
      default: s.craft_mass = $urandom_range(0, 65535);
    endcase
    return s;
  endfunction

  task automatic send_sample(input attitude_sample_t s, input logic typed,
                             input thrust_cmd_t fixed_res);
    int unsigned gap;
    gap = src_fast ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, s.craft_mass, s.angle_deadband, s.rotation_rate,
                      s.current_angle, s.target_angle};
    s_axis_tuser  <= s.axis_select;
    staged_cmd    <= typed ? fixed_res : predict_thrust(s);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_INERTIA_PITCH, CFG_INERTIA_YAW, CFG_INERTIA_ROLL: inertia_q[idx] = val;
      CFG_TORQUE_PITCH, CFG_TORQUE_YAW, CFG_TORQUE_ROLL: torque_q[idx - CFG_TORQUE_PITCH] = val;
      default: step_q = val;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] inr_pitch, input logic [31:0] inr_yaw,
                               input logic [31:0] inr_roll, input logic [31:0] trq_pitch,
                               input logic [31:0] trq_yaw, input logic [31:0] trq_roll,
                               input logic [31:0] step);
    write_reg(CFG_INERTIA_PITCH, inr_pitch);
    write_reg(CFG_INERTIA_YAW, inr_yaw);
    write_reg(CFG_INERTIA_ROLL, inr_roll);
    write_reg(CFG_TORQUE_PITCH, trq_pitch);
    write_reg(CFG_TORQUE_YAW, trq_yaw);
    write_reg(CFG_TORQUE_ROLL, trq_roll);
    write_reg(CFG_STEP_TIME, step);
    cfg_we_i <= 1'b0;
    src_fast = ($urandom_range(0, 3) == 0);
    sink_fast <= ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_sample(random_sample(), 1'b0, '0);
    drain_results();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // check results in order, then record the expectation of each accepted sample
  always @(posedge clk_i) begin
    thrust_cmd_t got;
    thrust_cmd_t want;
    int unsigned n;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.thrust_level = m_axis_tdata[15:0];
        got.reached      = m_axis_tdata[16];
        if (expected_cmds.size() == 0) begin
          $error("unexpected transfer: thrust_level %0d reached %0d",
                 got.thrust_level, got.reached);
          fault_count++;
        end else begin
          want = expected_cmds.pop_front();
          if (got.thrust_level !== want.thrust_level) begin
            $error("thrust_level: expected %0d, got %0d", want.thrust_level, got.thrust_level);
            fault_count++;
          end
          if (got.reached !== want.reached) begin
            $error("reached: expected %0d, got %0d", want.reached, got.reached);
            fault_count++;
          end
        end
        n = sink_fast ? 0 : $urandom_range(0, 7);
        stall_left <= n;
        m_axis_tready <= (n == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        if (stall_left == 1) m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) expected_cmds.push_back(staged_cmd);
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_INERTIA_PITCH;
    cfg_wdata_i   = '0;
    for (int k = 0; k < 3; k++) begin
      inertia_q[k] = 32'd65536;
      torque_q[k]  = 32'd256;
    end
    step_q   = 32'd65536;
    src_fast = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (step_cases[i]) send_sample(step_cases[i].s, step_cases[i].typed, step_cases[i].res);
    run_random(60);

    load_settings($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                  $urandom_range(0, 1 << 20), $urandom_range(1, 1 << 12),
                  $urandom_range(1, 1 << 12), $urandom_range(1, 1 << 12),
                  $urandom_range(656, 1 << 18));
    run_random(70);

    load_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    run_random(50);

    load_settings(32'd0, 32'd65536, 32'hFFFFFFFF, 32'd1, 32'd1, 32'd256, 32'd656);
    run_random(50);

    // zero pitch torque and zero step: any nonzero drive saturates in the sign of the rate error
    load_settings(32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd256, 32'hFFFFFFFF, 32'd0);
    run_random(40);

    load_settings($urandom, $urandom, $urandom, $urandom_range(1, 32'hFFFFFFFF),
                  $urandom_range(1, 32'hFFFFFFFF), $urandom_range(1, 32'hFFFFFFFF),
                  $urandom_range(656, 32'hFFFFFFFF));
    run_random(60);

    load_settings($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                  $urandom_range(0, 1 << 20), $urandom_range(1, 1 << 12),
                  $urandom_range(1, 1 << 12), $urandom_range(1, 1 << 12),
                  $urandom_range(656, 1 << 18));
    run_random(70);

    repeat (30) @(posedge clk_i);
    if (fault_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
